[rtl/core/yuts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuts_pkg
// Shared widths, character codes and byte classes for the unsafe token scanner.
// ----------------------------------------------------------------------------
package yuts_pkg;

   localparam int LINE_BITS   = 24;
   localparam int COLUMN_BITS = 16;

   typedef logic [7:0]             byte_type;
   typedef logic [LINE_BITS-1:0]   line_type;
   typedef logic [COLUMN_BITS-1:0] column_type;

   localparam line_type   LINE_ONE   = line_type'(1);
   localparam line_type   LINE_MAX   = '1;
   localparam column_type COLUMN_ONE = column_type'(1);
   localparam column_type COLUMN_MAX = '1;

   localparam byte_type CHAR_HASH      = 8'h23;
   localparam byte_type CHAR_AMPERSAND = 8'h26;
   localparam byte_type CHAR_STAR      = 8'h2A;
   localparam byte_type CHAR_BANG      = 8'h21;
   localparam byte_type CHAR_PERCENT   = 8'h25;
   localparam byte_type CHAR_COLON     = 8'h3A;
   localparam byte_type CHAR_DASH      = 8'h2D;
   localparam byte_type CHAR_LBRACKET  = 8'h5B;
   localparam byte_type CHAR_LBRACE    = 8'h7B;
   localparam byte_type CHAR_COMMA     = 8'h2C;
   localparam byte_type CHAR_BACKSLASH = 8'h5C;
   localparam byte_type CHAR_DQUOTE    = 8'h22;
   localparam byte_type CHAR_SQUOTE    = 8'h27;
   localparam byte_type CHAR_SPACE     = 8'h20;
   localparam byte_type CHAR_TAB       = 8'h09;
   localparam byte_type CHAR_NEWLINE   = 8'h0A;
   localparam byte_type CHAR_VTAB      = 8'h0B;
   localparam byte_type CHAR_FORMFEED  = 8'h0C;
   localparam byte_type CHAR_RETURN    = 8'h0D;

   localparam logic VERDICT_CLEAN  = 1'b0;
   localparam logic VERDICT_UNSAFE = 1'b1;

   function automatic logic is_separator(input byte_type b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_NEWLINE) ||
             (b == CHAR_VTAB) || (b == CHAR_FORMFEED) || (b == CHAR_RETURN) ||
             (b == CHAR_COLON) || (b == CHAR_DASH) || (b == CHAR_LBRACKET) ||
             (b == CHAR_LBRACE) || (b == CHAR_COMMA);
   endfunction

   function automatic logic is_unsafe(input byte_type b);
      return (b == CHAR_AMPERSAND) || (b == CHAR_STAR) || (b == CHAR_BANG) ||
             (b == CHAR_PERCENT);
   endfunction

endpackage
`default_nettype wire

[rtl/core/yuts_channels.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuts channels
// Valid/ready channel interfaces for text bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface yuts_req_if;
   logic                valid;
   logic                ready;
   yuts_pkg::byte_type  data_byte;
   logic                end_of_input;

   modport source (output valid, output data_byte, output end_of_input, input ready);
   modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface yuts_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 verdict;
   yuts_pkg::line_type   line_number;
   yuts_pkg::column_type column_number;

   modport source (output valid, output verdict, output line_number, output column_number,
                   input ready);
   modport sink   (input valid, input verdict, input line_number, input column_number,
                   output ready);
endinterface
`default_nettype wire

[rtl/core/yaml_unsafe_token_scanner.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yaml_unsafe_token_scanner
// Byte-serial YAML scan for anchors, aliases, tags and directives.
// ----------------------------------------------------------------------------
// Takes one byte per cycle: the quote, comment and boundary state and the
// line/column counters update in the cycle a byte is accepted, and any result
// lands in a one-deep output register, so a byte is accepted whenever that
// register is empty or being drained. Each document gives exactly one
// result: the first unsafe byte with its 1-based line and column, or a clean
// verdict with zero position on the byte marked end_of_input. Bytes after a
// finding are consumed silently; all state returns to reset after the last
// byte. No clearing pass is needed after reset.
module yaml_unsafe_token_scanner (
   input  wire logic   clock,
   input  wire logic   reset,
   yuts_req_if.sink    req_port,
   yuts_rsp_if.source  rsp_port
);
   import yuts_pkg::*;

   logic       in_single_ff, in_single_in;
   logic       in_double_ff, in_double_in;
   logic       escape_ff, escape_in;
   logic       in_comment_ff, in_comment_in;
   logic       close_pend_ff, close_pend_in;
   logic       boundary_ff, boundary_in;
   logic       stopped_ff, stopped_in;
   line_type   line_ff, line_in;
   column_type column_ff, column_in;

   logic       rsp_valid_ff;
   logic       verdict_ff;
   line_type   rsp_line_ff;
   column_type rsp_column_ff;

   logic       accept;
   logic       found;
   logic       emit;
   byte_type   b;
   logic       last;
   column_type column_next;
   line_type   line_next;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;
   assign b              = req_port.data_byte;
   assign last           = req_port.end_of_input;

   assign column_next = (column_ff == COLUMN_MAX) ? column_ff : column_ff + COLUMN_ONE;
   assign line_next   = (line_ff == LINE_MAX) ? line_ff : line_ff + LINE_ONE;

   always_comb begin
      in_single_in  = in_single_ff;
      in_double_in  = in_double_ff;
      escape_in     = escape_ff;
      in_comment_in = in_comment_ff;
      close_pend_in = close_pend_ff;
      boundary_in   = boundary_ff;
      stopped_in    = stopped_ff;
      line_in       = line_ff;
      column_in     = column_ff;
      found         = 1'b0;

      if (stopped_ff) begin
         // swallow bytes until the document ends
      end else if (in_comment_ff) begin
         if (b == CHAR_NEWLINE) begin
            in_comment_in = 1'b0;
            line_in       = line_next;
            column_in     = COLUMN_ONE;
            boundary_in   = 1'b1;
         end else begin
            column_in = column_next;
         end
      end else if (close_pend_ff && (b == CHAR_SQUOTE)) begin
         // doubled quote: reopen the single-quoted string
         close_pend_in = 1'b0;
         in_single_in  = 1'b1;
         boundary_in   = 1'b0;
         column_in     = column_next;
      end else begin
         close_pend_in = 1'b0;
         if (!in_single_ff && !in_double_ff && (b == CHAR_HASH)) begin
            in_comment_in = 1'b1;
            column_in     = column_next;
         end else if (b == CHAR_NEWLINE) begin
            in_single_in = 1'b0;
            in_double_in = 1'b0;
            escape_in    = 1'b0;
            line_in      = line_next;
            column_in    = COLUMN_ONE;
            boundary_in  = 1'b1;
         end else begin
            if (in_double_ff) begin
               if (escape_ff) begin
                  escape_in = 1'b0;
               end else if (b == CHAR_BACKSLASH) begin
                  escape_in = 1'b1;
               end else if (b == CHAR_DQUOTE) begin
                  in_double_in = 1'b0;
               end
            end else if (in_single_ff) begin
               if (b == CHAR_SQUOTE) begin
                  in_single_in  = 1'b0;
                  close_pend_in = 1'b1;
               end
            end else if (b == CHAR_DQUOTE) begin
               in_double_in = 1'b1;
            end else if (b == CHAR_SQUOTE) begin
               in_single_in = 1'b1;
            end else if (boundary_ff && is_unsafe(b)) begin
               found = 1'b1;
            end
            if (found) begin
               stopped_in = 1'b1;
            end else begin
               boundary_in = is_separator(b);
               column_in   = column_next;
            end
         end
      end

      // end of document returns everything to reset
      if (last) begin
         in_single_in  = 1'b0;
         in_double_in  = 1'b0;
         escape_in     = 1'b0;
         in_comment_in = 1'b0;
         close_pend_in = 1'b0;
         boundary_in   = 1'b1;
         stopped_in    = 1'b0;
         line_in       = LINE_ONE;
         column_in     = COLUMN_ONE;
      end
   end

   assign emit = found || (last && !stopped_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_single_ff  <= 1'b0;
         in_double_ff  <= 1'b0;
         escape_ff     <= 1'b0;
         in_comment_ff <= 1'b0;
         close_pend_ff <= 1'b0;
         boundary_ff   <= 1'b1;
         stopped_ff    <= 1'b0;
         line_ff       <= LINE_ONE;
         column_ff     <= COLUMN_ONE;
      end else if (accept) begin
         in_single_ff  <= in_single_in;
         in_double_ff  <= in_double_in;
         escape_ff     <= escape_in;
         in_comment_ff <= in_comment_in;
         close_pend_ff <= close_pend_in;
         boundary_ff   <= boundary_in;
         stopped_ff    <= stopped_in;
         line_ff       <= line_in;
         column_ff     <= column_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         verdict_ff    <= found ? VERDICT_UNSAFE : VERDICT_CLEAN;
         rsp_line_ff   <= found ? line_ff : '0;
         rsp_column_ff <= found ? column_ff : '0;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.verdict       = verdict_ff;
   assign rsp_port.line_number   = rsp_line_ff;
   assign rsp_port.column_number = rsp_column_ff;

   a_doc_end_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (!stopped_ff && boundary_ff && line_ff == LINE_ONE &&
                            column_ff == COLUMN_ONE && !in_comment_ff))
      else $error("state not restored after last byte");

   a_stop_with_finding: assert property (@(posedge clock) disable iff (reset)
      $rose(stopped_ff) |-> (rsp_valid_ff && verdict_ff == VERDICT_UNSAFE))
      else $error("scanner stopped without reporting a finding");

   a_clean_zero_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && verdict_ff == VERDICT_CLEAN) |->
         (rsp_line_ff == '0 && rsp_column_ff == '0))
      else $error("clean verdict carries a position");

   a_quote_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(in_single_ff && in_double_ff) && !(in_comment_ff && (in_single_ff || in_double_ff)))
      else $error("conflicting quote/comment state");

   a_escape_in_dquote: assert property (@(posedge clock) disable iff (reset)
      escape_ff |-> in_double_ff)
      else $error("escape pending outside double-quoted string");

endmodule
`default_nettype wire
